FILE: rtl/core/cfbd_pkg.sv
`default_nettype none

package cfbd_pkg;

    localparam int FRAME_BUFFER_BYTES_DEF = 32;

    localparam logic [7:0] SYNC_BYTE = 8'hA5;
    localparam logic [7:0] TAIL_BYTE = 8'h5A;
    localparam logic [7:0] EXT_FLAG  = 8'h10;
    localparam logic [7:0] LEN_MASK  = 8'h0F;

    localparam int LEN_W  = 4;
    localparam int OFF_W  = 5;    // holds any byte offset inside one frame (max 23 bytes)
    localparam int OUT_W  = 56;   // 49 payload bits padded to whole bytes
    localparam int PAD_W  = OUT_W - 49;

    // which byte of the buffered frame a read fetches
    typedef enum logic [2:0] {
        RD_HEAD,
        RD_CTRL,
        RD_FLAGS,
        RD_TAIL,
        RD_ID,
        RD_DATA
    } rd_kind_t;

    typedef struct packed {
        logic     wr_byte;
        logic     rd_req;
        rd_kind_t rd_kind;
        logic     cap_flags;
        logic     cap_ctrl;
        logic     clr_idx;
        logic     step_idx;
        logic     shift_id;
        logic     load_out;
        logic     drop_one;
        logic     drop_frame;
    } cfbd_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_lt3;
        logic full;
        logic rx_sync;
        logic frame_short;
        logic tail_ok;
        logic is_sync;
        logic id_done;
        logic data_done;
        logic out_free;
    } cfbd_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/can_frame_byte_deframer_unit.sv
// Results: a byte that completes a good frame starts the buffer reads for flags, tail, control,
// id and data bytes; each result is loaded into the output register once that register is free.
// Input: s_tready is high only in idle, so a new byte is taken only after the frame buffer
// read sequence for the last byte has ended; a bad-tail rescan adds reads for each dropped byte.
// Reset: control state and fill count clear at once; the frame buffer keeps its contents.
`default_nettype none

module can_frame_byte_deframer_unit
    import cfbd_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // rx_byte
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // port, extended, frame_id, length, data_byte, pad
    output logic                  m_tuser,   // byte_present
    output logic                  m_tlast
);

    cfbd_cmd_t cmd;
    cfbd_sts_t sts;

    cfbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfbd_dpath #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .rx_byte  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/core/cfbd_ctrl.sv
`default_nettype none

module cfbd_ctrl
    import cfbd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire cfbd_sts_t sts,
    output cfbd_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_FLAGS,
        S_LEN,
        S_TAIL,
        S_CTRL,
        S_IDRD,
        S_ID,
        S_DRD,
        S_DOUT,
        S_SCAN,
        S_SCHK
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_kind = RD_HEAD;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                // a byte is kept only once a sync heads the buffer
                if (in_valid && !sts.full && (!sts.count_zero || sts.rx_sync))
                begin
                    cmd.wr_byte = 1'b1;
                    state_next  = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.count_lt3)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_req  = 1'b1;
                    cmd.rd_kind = RD_FLAGS;
                    state_next  = S_FLAGS;
                end
            end
            S_FLAGS:
            begin
                cmd.cap_flags = 1'b1;
                state_next    = S_LEN;
            end
            S_LEN:
            begin
                if (sts.frame_short)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_req  = 1'b1;
                    cmd.rd_kind = RD_TAIL;
                    state_next  = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (!sts.tail_ok)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    cmd.rd_req  = 1'b1;
                    cmd.rd_kind = RD_CTRL;
                    cmd.clr_idx = 1'b1;
                    state_next  = S_CTRL;
                end
            end
            S_CTRL:
            begin
                cmd.cap_ctrl = 1'b1;
                state_next   = S_IDRD;
            end
            S_IDRD:
            begin
                cmd.rd_req  = 1'b1;
                cmd.rd_kind = RD_ID;
                state_next  = S_ID;
            end
            S_ID:
            begin
                cmd.shift_id = 1'b1;
                if (sts.id_done)
                begin
                    cmd.clr_idx = 1'b1;
                    state_next  = S_DRD;
                end
                else
                begin
                    cmd.step_idx = 1'b1;
                    state_next   = S_IDRD;
                end
            end
            S_DRD:
            begin
                cmd.rd_req  = 1'b1;
                cmd.rd_kind = RD_DATA;
                state_next  = S_DOUT;
            end
            S_DOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.data_done)
                    begin
                        cmd.drop_frame = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        cmd.step_idx = 1'b1;
                        state_next   = S_DRD;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.count_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_req  = 1'b1;
                    cmd.rd_kind = RD_HEAD;
                    state_next  = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (sts.is_sync)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cfbd_dpath.sv
`default_nettype none

module cfbd_dpath
    import cfbd_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfbd_cmd_t        cmd,
    output cfbd_sts_t             sts,
    input  wire logic [7:0]       rx_byte,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int PW = $clog2(FRAME_BUFFER_BYTES);
    localparam int CW = $clog2(FRAME_BUFFER_BYTES + 1);
    localparam int SW = PW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(FRAME_BUFFER_BYTES);
    localparam logic [CW-1:0] DEPTH_C = CW'(FRAME_BUFFER_BYTES);
    localparam logic [OFF_W-1:0] HDR_CLASSIC = OFF_W'(5);
    localparam logic [OFF_W-1:0] HDR_EXT     = OFF_W'(8);

    logic [7:0]       mem [FRAME_BUFFER_BYTES];
    logic [7:0]       rd_data_reg;
    logic [PW-1:0]    head_reg;
    logic [PW-1:0]    head_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [3:0]       port_reg;
    logic             ext_reg;
    logic [LEN_W-1:0] len_reg;
    logic [31:0]      id_reg;
    logic [LEN_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_user_reg;
    logic             out_last_reg;

    logic [OFF_W-1:0] total;
    logic [OFF_W-1:0] rd_off;
    logic [OFF_W-1:0] drop_amt;
    logic [SW-1:0]    rd_sum;
    logic [SW-1:0]    wr_sum;
    logic [SW-1:0]    drop_sum;
    logic [PW-1:0]    rd_addr;
    logic [PW-1:0]    wr_addr;
    logic [7:0]       out_byte;

    assign total = {1'b0, len_reg} + (ext_reg ? HDR_EXT : HDR_CLASSIC);

    always_comb
    begin
        case (cmd.rd_kind)
            RD_HEAD:  rd_off = OFF_W'(0);
            RD_CTRL:  rd_off = OFF_W'(1);
            RD_FLAGS: rd_off = OFF_W'(2);
            RD_TAIL:  rd_off = total - OFF_W'(1);
            RD_ID:    rd_off = OFF_W'(3) + OFF_W'(idx_reg);
            RD_DATA:  rd_off = (ext_reg ? OFF_W'(7) : OFF_W'(4)) + OFF_W'(idx_reg);
            default:  rd_off = OFF_W'(0);
        endcase
    end

    // circular addressing: offsets stay below the depth, so one subtract wraps
    always_comb
    begin
        rd_sum = {1'b0, head_reg} + SW'(rd_off);
        if (rd_sum >= DEPTH_S)
        begin
            rd_sum = rd_sum - DEPTH_S;
        end
        rd_addr = rd_sum[PW-1:0];

        wr_sum = {1'b0, head_reg} + SW'(count_reg[PW-1:0]);
        if (wr_sum >= DEPTH_S)
        begin
            wr_sum = wr_sum - DEPTH_S;
        end
        wr_addr = wr_sum[PW-1:0];
    end

    always_comb
    begin
        drop_amt = cmd.drop_frame ? total : OFF_W'(1);
        drop_sum = {1'b0, head_reg} + SW'(drop_amt);
        if (drop_sum >= DEPTH_S)
        begin
            drop_sum = drop_sum - DEPTH_S;
        end
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.wr_byte)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.drop_one || cmd.drop_frame)
        begin
            head_next  = drop_sum[PW-1:0];
            count_next = count_reg - CW'(drop_amt);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            mem[wr_addr] <= rx_byte;
        end
        if (cmd.rd_req)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.clr_idx)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step_idx)
            begin
                idx_reg <= idx_reg + LEN_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_byte = (len_reg != '0) ? rd_data_reg : 8'h00;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_flags)
        begin
            ext_reg <= (rd_data_reg & EXT_FLAG) != 8'h00;
            len_reg <= LEN_W'(rd_data_reg & LEN_MASK);
        end
        if (cmd.cap_ctrl)
        begin
            port_reg <= rd_data_reg[3:0];
        end
        // cleared with the index so a classic id comes out zero-extended
        if (cmd.clr_idx && !cmd.shift_id)
        begin
            id_reg <= '0;
        end
        else if (cmd.shift_id)
        begin
            id_reg <= {id_reg[23:0], rd_data_reg};
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, out_byte, len_reg, id_reg, ext_reg, port_reg};
            out_user_reg <= len_reg != '0;
            out_last_reg <= sts.data_done;
        end
    end

    assign sts.count_zero  = count_reg == '0;
    assign sts.count_lt3   = count_reg < CW'(3);
    assign sts.full        = count_reg == DEPTH_C;
    assign sts.rx_sync     = rx_byte == SYNC_BYTE;
    assign sts.frame_short = count_reg < CW'(total);
    assign sts.tail_ok     = rd_data_reg == TAIL_BYTE;
    assign sts.is_sync     = rd_data_reg == SYNC_BYTE;
    assign sts.id_done     = idx_reg == (ext_reg ? LEN_W'(3) : LEN_W'(0));
    assign sts.data_done   = (len_reg == '0) || (idx_reg == len_reg - LEN_W'(1));
    assign sts.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("buffer fill beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_byte |-> !sts.full)
        else $error("write into a full buffer");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_frame |-> !sts.frame_short)
        else $error("frame drop larger than fill");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_one |-> !sts.count_zero)
        else $error("byte drop from an empty buffer");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(out_data_reg))
        else $error("result overwritten before transaction");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/can_frame_byte_deframer_unit_test.sv
`timescale 1ns / 1ps

module can_frame_byte_deframer_unit_test;
    import cfbd_pkg::*;

    localparam int STREAM_BYTES = 380;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic [3:0]  port;
        logic        extended;
        logic [31:0] frame_id;
        logic [3:0]  length;
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        last_flag;
    } can_result_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    class deframe_scoreboard;
        logic [7:0]  held [FRAME_BUFFER_BYTES_DEF];
        int unsigned held_count;
        can_result_t pending [$];
        int unsigned errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // drop n bytes from the head, then any non-sync bytes behind them
        function void discard_head(int unsigned n);
            int unsigned k;
            int unsigned j;
            k = (n > held_count) ? held_count : n;
            while (k < held_count && held[k] != SYNC_BYTE)
                k++;
            for (j = 0; j + k < held_count; j++)
                held[j] = held[j + k];
            held_count -= k;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0]  flg;
            logic        ext;
            logic [31:0] fid;
            int unsigned id_len;
            int unsigned data_len;
            int unsigned span;
            int unsigned need;
            int unsigned produced;
            int unsigned i;
            bit          scanning;
            can_result_t r;
            produced = 0;
            if (held_count < FRAME_BUFFER_BYTES_DEF && (held_count != 0 || b == SYNC_BYTE))
            begin
                held[held_count] = b;
                held_count++;
            end
            scanning = 1'b1;
            while (scanning && held_count >= 3)
            begin
                flg      = held[2];
                ext      = (flg & EXT_FLAG) != 8'h00;
                data_len = int'(flg & LEN_MASK);
                id_len   = ext ? 4 : 1;
                span     = 4 + id_len + data_len;
                if (held_count < span)
                begin
                    scanning = 1'b0;
                end
                else if (held[span - 1] != TAIL_BYTE)
                begin
                    discard_head(1);
                end
                else
                begin
                    need = (data_len != 0) ? data_len : 1;
                    if (produced + need > 32)
                    begin
                        scanning = 1'b0;
                    end
                    else
                    begin
                        fid = ext ? {held[3], held[4], held[5], held[6]} : {24'h0, held[3]};
                        for (i = 0; i < need; i++)
                        begin
                            r.port         = held[1][3:0];
                            r.extended     = ext;
                            r.frame_id     = fid;
                            r.length       = data_len[3:0];
                            r.data_byte    = (data_len != 0) ? held[3 + id_len + i] : 8'h00;
                            r.byte_present = (data_len != 0);
                            r.last_flag    = (i + 1 == need);
                            pending.insert(pending.size(), r);
                        end
                        produced += need;
                        discard_head(span);
                    end
                end
            end
        endfunction

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(logic [OUT_W-1:0] d, logic u, logic l);
            can_result_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result tdata %0h tuser %0b tlast %0b", d, u, l));
            end
            else
            begin
                e = pending.pop_front();
                cmp_field("port", 32'(d[3:0]), 32'(e.port));
                cmp_field("extended", 32'(d[4]), 32'(e.extended));
                cmp_field("frame_id", d[36:5], e.frame_id);
                cmp_field("length", 32'(d[40:37]), 32'(e.length));
                cmp_field("data_byte", 32'(d[48:41]), 32'(e.data_byte));
                cmp_field("byte_present", 32'(u), 32'(e.byte_present));
                cmp_field("last", 32'(l), 32'(e.last_flag));
            end
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    deframe_scoreboard sb;
    logic [7:0]        rx_stream [$];
    int unsigned       idle_cycles = 0;
    int unsigned       stall_clock = 0;
    ready_mode_t       ready_mode  = READY_ALWAYS;

    can_frame_byte_deframer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic void stash_byte(logic [7:0] b);
        rx_stream.insert(rx_stream.size(), b);
    endfunction

    // biased towards the sync value so that rescans find embedded frames
    function automatic logic [7:0] link_byte();
        return ($urandom_range(0, 7) == 0) ? SYNC_BYTE : 8'($urandom);
    endfunction

    function automatic void add_frame(logic [7:0] ctrl, logic [7:0] flags, logic [31:0] fid,
                                      logic [7:0] tail);
        int n;
        stash_byte(SYNC_BYTE);
        stash_byte(ctrl);
        stash_byte(flags);
        if ((flags & EXT_FLAG) != 8'h00)
        begin
            stash_byte(fid[31:24]);
            stash_byte(fid[23:16]);
            stash_byte(fid[15:8]);
        end
        stash_byte(fid[7:0]);
        for (n = 0; n < int'(flags & LEN_MASK); n++)
            stash_byte(link_byte());
        stash_byte(tail);
    endfunction

    task automatic send_byte(logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b);
    endtask

    // receiver side: check on each transaction, drive m_tready from a randomly redrawn stall pattern
    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
        stall_clock++;
        if (stall_clock % 64 == 0)
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            default:        m_tready <= stall_clock[2];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0]  flags;
        logic [7:0]  tail;
        int unsigned pick;
        int unsigned n;
        int unsigned idx;
        int unsigned burst;
        int unsigned gap;
        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;

        // garbage ahead of any sync
        stash_byte(8'h00);
        stash_byte(8'hFF);
        // classic empty frame, top port, id all ones
        add_frame(8'h0F, 8'h00, 32'h0000_00FF, TAIL_BYTE);
        // extended frame, upper flag bits set, id all ones, port 0
        add_frame(8'hF0, 8'hF1, 32'hFFFF_FFFF, TAIL_BYTE);
        // bad tail: sync dropped, rescan finds a frame starting at the second sync
        stash_byte(SYNC_BYTE);
        stash_byte(SYNC_BYTE);
        stash_byte(8'h00);
        stash_byte(8'h00);
        stash_byte(8'h77);
        stash_byte(TAIL_BYTE);

        while (rx_stream.size() < STREAM_BYTES)
        begin
            pick  = $urandom_range(0, 99);
            flags = 8'($urandom);
            if (pick < 70)
            begin
                add_frame(8'($urandom), flags, $urandom, TAIL_BYTE);
            end
            else if (pick < 85)
            begin
                tail = 8'($urandom);
                if (tail == TAIL_BYTE)
                    tail = tail ^ 8'h01;
                add_frame(link_byte(), flags, {link_byte(), link_byte(), link_byte(),
                          link_byte()}, tail);
            end
            else
            begin
                for (n = $urandom_range(1, 4); n > 0; n--)
                    stash_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idx = 0;
        while (idx < rx_stream.size())
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && idx < rx_stream.size())
            begin
                send_byte(rx_stream[idx]);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            // one long stretch with the sender never idle
            if (idx >= 150 && idx < 230)
                gap = 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/cfbd_pkg.sv
rtl/core/cfbd_ctrl.sv
rtl/core/cfbd_dpath.sv
rtl/core/can_frame_byte_deframer_unit.sv
tb/sv/can_frame_byte_deframer_unit_test.sv
